/* rtl/core/dmc_pkg.sv */
// Shared constants, types and helpers of the depth-first maze carver.
package dmc_pkg;

  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int RCNT_W   = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W   = $clog2(MAX_COLS + 1);
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int SP_W     = ADDR_W + 1;
  localparam int STK_W    = ROW_W + COL_W;

  // generation tags of the visited map
  localparam int EPOCH_W = 4;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  // field widths of the stream items
  localparam int RV_W     = 8;
  localparam int STAT_W   = 3;
  localparam int ROWF_W   = 5;
  localparam int COLF_W   = 5;
  localparam int DIR_W    = 2;
  localparam int DEPTH_W  = 11;
  localparam int CFG_W    = 6;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_DATA_W = 24;

  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  localparam logic [STAT_W-1:0] ST_STARTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_CARVED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_BACKTRACK = 3'd2;
  localparam logic [STAT_W-1:0] ST_FINISHED = 3'd3;
  localparam logic [STAT_W-1:0] ST_OUTSIDE  = 3'd4;

  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_COL = 3'd3;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [ROWF_W-1:0]  cell_row;
    logic [COLF_W-1:0]  cell_col;
    logic [DIR_W-1:0]   direction;
    logic [DEPTH_W-1:0] stack_depth;
  } res_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [EPOCH_W-1:0] tag;
  } vwr_t;

  typedef struct packed {
    logic             any;
    logic [DIR_W-1:0] dir;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pick_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    cell_addr = ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
  endfunction

endpackage

/* rtl/core/dmc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module dmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/dmc_visit.sv */
// Visited map: four replicas of the generation-tag memory, one per neighbor.
module dmc_visit
  import dmc_pkg::*;
(
  input  logic               clk,
  input  vwr_t               wr,
  input  logic [ADDR_W-1:0]  rd_addr [4],
  input  logic [EPOCH_W-1:0] epoch,
  output logic [3:0]         vis
);

  logic [EPOCH_W-1:0] tag_q [4];

  for (genvar g = 0; g < 4; g++) begin : g_copy
    dmc_ram #(
      .WIDTH(EPOCH_W),
      .DEPTH(CELLS)
    ) u_ram (
      .clk  (clk),
      .we   (wr.en),
      .waddr(wr.addr),
      .wdata(wr.tag),
      .raddr(rd_addr[g]),
      .rdata(tag_q[g])
    );
    // a cell is visited when its tag matches the current generation
    assign vis[g] = (tag_q[g] == epoch);
  end

endmodule

/* rtl/core/dmc_pick.sv */
// Neighbor test and random choice among the unvisited neighbors of the top cell.
module dmc_pick
  import dmc_pkg::*;
(
  input  logic [ROW_W-1:0]  top_row,
  input  logic [COL_W-1:0]  top_col,
  input  logic [RCNT_W-1:0] rows,
  input  logic [CCNT_W-1:0] cols,
  input  logic [3:0]        vis,
  input  logic [RV_W-1:0]   rv,
  output pick_t             pick
);

  logic [3:0] ok;
  logic [2:0] n;
  logic [1:0] k;
  logic [1:0] sel;
  logic       row_in;
  logic       col_in;

  // remainder by three: fold base-4 digits, then correct
  function automatic logic [1:0] mod3(input logic [RV_W-1:0] v);
    logic [3:0] s;
    logic [2:0] t;
    s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
    t = 3'(s[1:0]) + 3'(s[3:2]);
    if (t >= 3'd3) t = t - 3'd3;
    if (t >= 3'd3) t = t - 3'd3;
    mod3 = t[1:0];
  endfunction

  always_comb begin
    row_in = (RCNT_W'(top_row) < rows);
    col_in = (CCNT_W'(top_col) < cols);
    ok[0] = (RCNT_W'(top_row) + RCNT_W'(1) < rows) && col_in && !vis[0];
    ok[1] = (top_row != '0) && (RCNT_W'(top_row) - RCNT_W'(1) < rows) && col_in && !vis[1];
    ok[2] = (top_col != '0) && (CCNT_W'(top_col) - CCNT_W'(1) < cols) && row_in && !vis[2];
    ok[3] = (CCNT_W'(top_col) + CCNT_W'(1) < cols) && row_in && !vis[3];
    n = 3'($countones(ok));
  end

  always_comb begin
    case (n)
      3'd2:    k = {1'b0, rv[0]};
      3'd3:    k = mod3(rv);
      3'd4:    k = rv[1:0];
      default: k = 2'd0;
    endcase
  end

  // take the k-th candidate in up, down, left, right order
  always_comb begin
    logic [2:0] seen;
    logic       found;
    seen  = 3'd0;
    found = 1'b0;
    sel   = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (ok[i]) begin
        if (!found && seen == {1'b0, k}) begin
          sel   = 2'(i);
          found = 1'b1;
        end
        seen = seen + 3'd1;
      end
    end
  end

  always_comb begin
    pick.any = (n != 3'd0);
    pick.row = top_row;
    pick.col = top_col;
    case (sel)
      2'd0:    begin pick.dir = DIR_UP;    pick.row = top_row + ROW_W'(1); end
      2'd1:    begin pick.dir = DIR_DOWN;  pick.row = top_row - ROW_W'(1); end
      2'd2:    begin pick.dir = DIR_LEFT;  pick.col = top_col - COL_W'(1); end
      default: begin pick.dir = DIR_RIGHT; pick.col = top_col + COL_W'(1); end
    endcase
  end

endmodule

/* rtl/core/dmc_obuf.sv */
// Two-entry result buffer between the carving engine and the output stream.
module dmc_obuf
  import dmc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_res,
  output logic full,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  res_t       slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign out_res   = slot_r[rptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_res;
    end
  end

endmodule

/* rtl/core/dfs_maze_carver.sv */
// Top level of the depth-first maze carver: control, path stack and stack top.
//
// After reset the block sweeps its visited memory and accepts no item until
// the sweep ends; configuration writes are taken at any time. For an advance
// item the four neighbor tags and the stack entry below the top are read from
// the visited and stack memories in the cycle of accept, and the choice, the
// write back and the result follow in the next cycle. An advance on an empty
// stack pushes its result in the cycle of accept. The visited map is cleared
// by bumping a 4-bit generation tag, so every fifteenth start adds a sweep of
// the visited memory. Results pass through a two-entry buffer, so one waiting
// result does not stop input; with two results waiting, input holds until one
// of them leaves.
module dfs_maze_carver
  import dmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: random_value[7:0]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [RV_W-1:0]       in_tdata,
  // in_tuser: kind[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata: cell_row[4:0], cell_col[9:5], direction[11:10],
  //            stack_depth[22:12], zero[23]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: status[2:0]
  output logic [STAT_W-1:0]     out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_STEP  = 2'd2;
  localparam logic [1:0] S_START = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic               pend_r, pend_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [SP_W-1:0]    sp_r, sp_nxt;
  logic [ROW_W-1:0]   top_row_r, top_row_nxt;
  logic [COL_W-1:0]   top_col_r, top_col_nxt;
  logic [RV_W-1:0]    rv_r, rv_nxt;

  logic [CFG_W-1:0]   row_count_r, row_count_nxt;
  logic [CFG_W-1:0]   col_count_r, col_count_nxt;
  logic [ROWF_W-1:0]  start_row_r, start_row_nxt;
  logic [COLF_W-1:0]  start_col_r, start_col_nxt;

  logic [RCNT_W-1:0]  rows;
  logic [CCNT_W-1:0]  cols;
  logic [ROW_W-1:0]   srow;
  logic [COL_W-1:0]   scol;
  logic               start_out;

  logic               in_acc;
  logic               obuf_full;
  logic               push;
  res_t               push_res;
  res_t               out_res;

  vwr_t               vwr;
  logic [ADDR_W-1:0]  vrd_addr [4];
  logic [3:0]         vis;
  pick_t              pick;

  logic               stk_we;
  logic [ADDR_W-1:0]  stk_waddr;
  logic [STK_W-1:0]   stk_wdata;
  logic [ADDR_W-1:0]  stk_raddr;
  logic [STK_W-1:0]   stk_rdata;
  logic [SP_W-1:0]    sp_less2;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE) && !obuf_full;
  assign in_acc    = in_tvalid && in_tready;

  // effective grid size: zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (row_count_r == '0) begin
      rows = RCNT_W'(1);
    end else if (int'(row_count_r) > MAX_ROWS) begin
      rows = RCNT_W'(MAX_ROWS);
    end else begin
      rows = RCNT_W'(row_count_r);
    end
    if (col_count_r == '0) begin
      cols = CCNT_W'(1);
    end else if (int'(col_count_r) > MAX_COLS) begin
      cols = CCNT_W'(MAX_COLS);
    end else begin
      cols = CCNT_W'(col_count_r);
    end
    srow      = ROW_W'(start_row_r);
    scol      = COL_W'(start_col_r);
    start_out = (int'(start_row_r) >= int'(rows)) || (int'(start_col_r) >= int'(cols));
  end

  always_comb begin
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    start_row_nxt = start_row_r;
    start_col_nxt = start_col_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW_COUNT: row_count_nxt = cfg_data;
        REG_COL_COUNT: col_count_nxt = cfg_data;
        REG_START_ROW: start_row_nxt = cfg_data[ROWF_W-1:0];
        REG_START_COL: start_col_nxt = cfg_data[COLF_W-1:0];
        default: ;
      endcase
    end
  end

  // neighbor reads at accept; out-of-grid addresses wrap and are masked later
  assign vrd_addr[0] = cell_addr(top_row_r + ROW_W'(1), top_col_r);
  assign vrd_addr[1] = cell_addr(top_row_r - ROW_W'(1), top_col_r);
  assign vrd_addr[2] = cell_addr(top_row_r, top_col_r - COL_W'(1));
  assign vrd_addr[3] = cell_addr(top_row_r, top_col_r + COL_W'(1));

  // entry below the top, needed when this step pops
  assign sp_less2  = sp_r - SP_W'(2);
  assign stk_raddr = sp_less2[ADDR_W-1:0];

  dmc_visit u_visit (
    .clk    (clk),
    .wr     (vwr),
    .rd_addr(vrd_addr),
    .epoch  (epoch_r),
    .vis    (vis)
  );

  dmc_ram #(
    .WIDTH(STK_W),
    .DEPTH(CELLS)
  ) u_stack (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

  dmc_pick u_pick (
    .top_row(top_row_r),
    .top_col(top_col_r),
    .rows   (rows),
    .cols   (cols),
    .vis    (vis),
    .rv     (rv_r),
    .pick   (pick)
  );

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    pend_nxt    = pend_r;
    epoch_nxt   = epoch_r;
    sp_nxt      = sp_r;
    top_row_nxt = top_row_r;
    top_col_nxt = top_col_r;
    rv_nxt      = rv_r;
    vwr         = '0;
    stk_we      = 1'b0;
    stk_waddr   = sp_r[ADDR_W-1:0];
    stk_wdata   = {top_row_r, top_col_r};
    push        = 1'b0;
    push_res    = '0;

    unique case (state_r)
      S_CLEAR: begin
        vwr.en      = 1'b1;
        vwr.addr    = clr_cnt_r;
        vwr.tag     = '0;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(CELLS - 1)) begin
          epoch_nxt = EPOCH_FIRST;
          pend_nxt  = 1'b0;
          state_nxt = pend_r ? S_START : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == KIND_START) begin
            if (epoch_r == EPOCH_MAX) begin
              clr_cnt_nxt = '0;
              pend_nxt    = 1'b1;
              state_nxt   = S_CLEAR;
            end else begin
              epoch_nxt = epoch_r + EPOCH_W'(1);
              state_nxt = S_START;
            end
          end else if (sp_r == '0) begin
            push            = 1'b1;
            push_res.status = ST_FINISHED;
          end else begin
            rv_nxt    = in_tdata;
            state_nxt = S_STEP;
          end
        end
      end
      S_START: begin
        state_nxt = S_IDLE;
        push      = 1'b1;
        if (start_out) begin
          sp_nxt          = '0;
          push_res.status = ST_OUTSIDE;
        end else begin
          vwr.en      = 1'b1;
          vwr.addr    = cell_addr(srow, scol);
          vwr.tag     = epoch_r;
          stk_we      = 1'b1;
          stk_waddr   = '0;
          stk_wdata   = {srow, scol};
          top_row_nxt = srow;
          top_col_nxt = scol;
          sp_nxt      = SP_W'(1);
          push_res.status      = ST_STARTED;
          push_res.cell_row    = ROWF_W'(srow);
          push_res.cell_col    = COLF_W'(scol);
          push_res.stack_depth = DEPTH_W'(SP_W'(1));
        end
      end
      S_STEP: begin
        state_nxt         = S_IDLE;
        push              = 1'b1;
        push_res.cell_row = ROWF_W'(top_row_r);
        push_res.cell_col = COLF_W'(top_col_r);
        if (pick.any && sp_r != SP_W'(CELLS)) begin
          vwr.en      = 1'b1;
          vwr.addr    = cell_addr(pick.row, pick.col);
          vwr.tag     = epoch_r;
          stk_we      = 1'b1;
          stk_wdata   = {pick.row, pick.col};
          top_row_nxt = pick.row;
          top_col_nxt = pick.col;
          sp_nxt      = sp_r + SP_W'(1);
          push_res.status      = ST_CARVED;
          push_res.direction   = pick.dir;
          push_res.stack_depth = DEPTH_W'(sp_r + SP_W'(1));
        end else begin
          // pop: the entry below the top was read at accept
          {top_row_nxt, top_col_nxt} = stk_rdata;
          sp_nxt               = sp_r - SP_W'(1);
          push_res.status      = ST_BACKTRACK;
          push_res.stack_depth = DEPTH_W'(sp_r - SP_W'(1));
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      epoch_r     <= '0;
      sp_r        <= '0;
      row_count_r <= CFG_W'(30);
      col_count_r <= CFG_W'(30);
      start_row_r <= '0;
      start_col_r <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      epoch_r     <= epoch_nxt;
      sp_r        <= sp_nxt;
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
      start_row_r <= start_row_nxt;
      start_col_r <= start_col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_row_r <= top_row_nxt;
    top_col_r <= top_col_nxt;
    rv_r      <= rv_nxt;
  end

  dmc_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_res (push_res),
    .full     (obuf_full),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (out_res)
  );

  assign out_tuser = out_res.status;
  assign out_tdata = {1'b0, out_res.stack_depth, out_res.direction,
                      out_res.cell_col, out_res.cell_row};

endmodule

/* rtl/core/dmc_checker.sv */
// Port-level checks of the maze carver, bound to the top level.
module dmc_checker
  import dmc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [STAT_W-1:0]     out_tuser
);

  // a start always occupies the engine, so input is not ready right after its accept
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == KIND_START) |=> !in_tready)
    else $error("input ready right after a start item");

  a_started_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_STARTED) |-> (out_tdata[22:12] == 11'd1))
    else $error("started result without a single-cell stack");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_OUTSIDE || out_tuser == ST_FINISHED))
      |-> (out_tdata == '0))
    else $error("finished or outside result carries nonzero fields");

  a_dir_carve: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_CARVED) |-> (out_tdata[11:10] == DIR_UP))
    else $error("direction set on a result that carved nothing");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind dfs_maze_carver dmc_checker u_dmc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
